// File: rtl/core/dsd_pkg.sv
// Shared types and constants for the dual encoder speed/distance block.
// Used by the front, back and top-level modules; depends on nothing.
package dsd_pkg;

  typedef struct packed {
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
    logic ms_tick;
    logic clear_distance;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_rpm;
    logic signed [15:0] right_rpm;
    logic signed [31:0] left_distance_mm;
    logic signed [31:0] right_distance_mm;
    logic               speed_new;
  } out_word_t;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_WINDOW_MS      = 2'd0;
  localparam logic [1:0] REG_PULSES_PER_REV = 2'd1;
  localparam logic [1:0] REG_MM_PER_PULSE   = 2'd2;

  localparam logic [15:0] WINDOW_MS_RST      = 16'd100;
  localparam logic [15:0] PULSES_PER_REV_RST = 16'd360;
  localparam logic [23:0] MM_PER_PULSE_RST   = 24'd65536;

  // Arithmetic constants
  localparam logic [23:0] RPM_SCALE = 24'd60000;   // 60 s * 1000 ms
  localparam int          RPM_QBITS = 15;          // quotient bits below saturation
  localparam logic [14:0] RPM_QMAX  = 15'h7FFF;
  localparam logic [30:0] DIST_MAX  = 31'h7FFF_FFFF;
  localparam int          FRAC_BITS = 16;          // Q8.16 travel per pulse

endpackage

// File: rtl/core/dsd_front.sv
// Front end: edge detection, saturating pulse counters and the ms window.
// Emits one job word per accepted sample. Depends on dsd_pkg.
module dsd_front #(
  parameter int COUNT_WIDTH = 32,
  parameter int JOB_W       = 1 + 32 + 4 * COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dsd_pkg::in_word_t in_word,
  input  logic              full,
  input  logic [15:0]       window_ms,
  input  logic [15:0]       pulses_per_rev,
  output logic              job_push,
  output logic [JOB_W-1:0]  job_data
);

  localparam int CW = COUNT_WIDTH;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-2){1'b0}}, 1'b1};

  function automatic logic signed [CW-1:0] sat_step(input logic signed [CW-1:0] v,
                                                     input logic up);
    logic signed [CW-1:0] r;
    if (up) begin
      r = (v == CMAX) ? v : v + CW'(1);
    end else begin
      r = (v == CMIN) ? v : v - CW'(1);
    end
    return r;
  endfunction

  logic                 prev_la_r, prev_la_nxt;
  logic                 prev_ra_r, prev_ra_nxt;
  logic signed [CW-1:0] lw_r, lw_nxt, rw_r, rw_nxt;
  logic signed [CW-1:0] lt_r, lt_nxt, rt_r, rt_nxt;
  logic [15:0]          elapsed_r, elapsed_nxt;

  logic                 accept;
  logic                 edge_l, edge_r;
  logic signed [CW-1:0] lt_base, rt_base;
  logic signed [CW-1:0] lw_new, rw_new, lt_new, rt_new;
  logic [16:0]          n_ms;
  logic [15:0]          wm_eff, ppr_eff;
  logic                 close;
  logic [31:0]          divisor;

  assign accept = push & ~full;

  always_comb begin
    edge_l  = in_word.left_a & ~prev_la_r;
    edge_r  = in_word.right_a & ~prev_ra_r;
    // clear first, then count this sample's edge
    lt_base = in_word.clear_distance ? '0 : lt_r;
    rt_base = in_word.clear_distance ? '0 : rt_r;
    lw_new  = edge_l ? sat_step(lw_r, in_word.left_b) : lw_r;
    lt_new  = edge_l ? sat_step(lt_base, in_word.left_b) : lt_base;
    rw_new  = edge_r ? sat_step(rw_r, in_word.right_b) : rw_r;
    rt_new  = edge_r ? sat_step(rt_base, in_word.right_b) : rt_base;

    n_ms    = {1'b0, elapsed_r} + 17'd1;
    wm_eff  = (window_ms == 16'd0) ? 16'd1 : window_ms;
    ppr_eff = (pulses_per_rev == 16'd0) ? 16'd1 : pulses_per_rev;
    close   = in_word.ms_tick & (n_ms >= {1'b0, wm_eff});
    divisor = 32'(ppr_eff) * 32'(n_ms[15:0]);

    prev_la_nxt = prev_la_r;
    prev_ra_nxt = prev_ra_r;
    lw_nxt      = lw_r;
    rw_nxt      = rw_r;
    lt_nxt      = lt_r;
    rt_nxt      = rt_r;
    elapsed_nxt = elapsed_r;
    if (accept) begin
      prev_la_nxt = in_word.left_a;
      prev_ra_nxt = in_word.right_a;
      lt_nxt      = lt_new;
      rt_nxt      = rt_new;
      lw_nxt      = close ? '0 : lw_new;
      rw_nxt      = close ? '0 : rw_new;
      if (in_word.ms_tick) begin
        elapsed_nxt = close ? 16'd0 : n_ms[15:0];
      end
    end
  end

  assign job_push = accept;
  assign job_data = {close, divisor, lw_new, rw_new, lt_new, rt_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_la_r <= 1'b0;
      prev_ra_r <= 1'b0;
      lw_r      <= '0;
      rw_r      <= '0;
      lt_r      <= '0;
      rt_r      <= '0;
      elapsed_r <= '0;
    end else begin
      prev_la_r <= prev_la_nxt;
      prev_ra_r <= prev_ra_nxt;
      lw_r      <= lw_nxt;
      rw_r      <= rw_nxt;
      lt_r      <= lt_nxt;
      rt_r      <= rt_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// File: rtl/core/dsd_fifo.sv
// Small job queue between the front end and the arithmetic back end.
// Register array with head/tail pointers; no package dependencies.
module dsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_data = mem[rp_r];
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + PW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + CNTW'(1);
      2'b01:   cnt_nxt = cnt_r - CNTW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/dsd_back.sv
// Back end: distance products, rpm division and the result register.
// Shares one 16x24 multiplier and one restoring divider. Depends on dsd_pkg.
module dsd_back #(
  parameter int COUNT_WIDTH = 32,
  parameter int JOB_W       = 1 + 32 + 4 * COUNT_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  logic [JOB_W-1:0]   job_data,
  output logic               job_take,
  input  logic [23:0]        mm_per_pulse_q16,
  output dsd_pkg::out_word_t out_word,
  output logic               empty,
  input  logic               pop
);

  localparam int CW   = COUNT_WIDTH;
  localparam int MW   = CW - 1;              // magnitude of a saturated count
  localparam int NCH  = MW / 16 + 1;         // 16-bit chunks per magnitude
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PADW = NCH * 16;
  localparam int AW   = PADW + 32;
  localparam int QB   = dsd_pkg::RPM_QBITS;
  localparam int STW  = $clog2(QB + 1);
  localparam logic [CHW-1:0] CHUNK_LAST = CHW'(NCH - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIST = 7'b0000100,
    S_DIVC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SPD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } back_state_t;

  function automatic logic [MW-1:0] magnitude(input logic signed [CW-1:0] v);
    logic [CW-1:0] t;
    t = v[CW-1] ? (~v + CW'(1)) : v;
    return t[MW-1:0];
  endfunction

  back_state_t state_r, state_nxt;
  logic        side_r, side_nxt;       // 0 left, 1 right
  logic        goal_r, goal_nxt;       // 0 distance, 1 rpm
  logic [CHW-1:0] chunk_r, chunk_nxt;
  logic [AW-1:0]  acc_r, acc_nxt;
  logic [31:0]    rem_r, rem_nxt;
  logic [QB-1:0]  numlo_r, numlo_nxt;
  logic [QB-1:0]  quot_r, quot_nxt;
  logic [STW-1:0] step_r, step_nxt;

  logic        close_r;
  logic [31:0] div_r;
  logic [MW-1:0] mag_lw_r, mag_rw_r, mag_lt_r, mag_rt_r;
  logic          neg_lw_r, neg_rw_r, neg_lt_r, neg_rt_r;

  logic signed [31:0] dist_l_r, dist_l_nxt, dist_r_r, dist_r_nxt;
  logic signed [15:0] spd_l_r, spd_l_nxt, spd_r_r, spd_r_nxt;
  logic               out_valid_r, out_valid_nxt;
  dsd_pkg::out_word_t out_word_r, out_word_nxt;

  logic signed [CW-1:0] j_lw, j_rw, j_lt, j_rt;
  logic [MW-1:0]   sel_mag;
  logic            sel_neg;
  logic [PADW-1:0] a_pad;
  logic [15:0]     chunk;
  logic [23:0]     mul_b;
  logic [39:0]     prod;
  logic [AW-17:0]  dfull;
  logic [30:0]     dmag;
  logic signed [31:0] dval;
  logic [AW-16:0]  num_hi;
  logic            ovf;
  logic [32:0]     trial;
  logic            qbit;
  logic signed [15:0] sval;

  assign j_lw = job_data[4*CW-1 -: CW];
  assign j_rw = job_data[3*CW-1 -: CW];
  assign j_lt = job_data[2*CW-1 -: CW];
  assign j_rt = job_data[CW-1:0];

  assign job_take = (state_r == S_IDLE) & job_valid;
  assign out_word = out_word_r;
  assign empty    = ~out_valid_r;

  always_comb begin
    case ({goal_r, side_r})
      2'b00:   begin sel_mag = mag_lt_r; sel_neg = neg_lt_r; end
      2'b01:   begin sel_mag = mag_rt_r; sel_neg = neg_rt_r; end
      2'b10:   begin sel_mag = mag_lw_r; sel_neg = neg_lw_r; end
      default: begin sel_mag = mag_rw_r; sel_neg = neg_rw_r; end
    endcase
    a_pad  = {{(PADW-MW){1'b0}}, sel_mag};
    chunk  = a_pad[{chunk_r, 4'b0000} +: 16];
    mul_b  = goal_r ? dsd_pkg::RPM_SCALE : mm_per_pulse_q16;
    prod   = 40'(chunk) * 40'(mul_b);

    dfull  = acc_r[AW-1:dsd_pkg::FRAC_BITS];
    dmag   = (|dfull[AW-17:31]) ? dsd_pkg::DIST_MAX : dfull[30:0];
    dval   = sel_neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

    num_hi = acc_r[AW-1:QB];
    ovf    = (num_hi >= {{(AW-QB-32){1'b0}}, div_r});
    trial  = {rem_r, numlo_r[QB-1]};
    qbit   = (trial >= {1'b0, div_r});
    sval   = sel_neg ? -$signed({1'b0, quot_r}) : $signed({1'b0, quot_r});
  end

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    goal_nxt      = goal_r;
    chunk_nxt     = chunk_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    numlo_nxt     = numlo_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    dist_l_nxt    = dist_l_r;
    dist_r_nxt    = dist_r_r;
    spd_l_nxt     = spd_l_r;
    spd_r_nxt     = spd_r_r;
    out_valid_nxt = out_valid_r & ~pop;
    out_word_nxt  = out_word_r;

    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          side_nxt  = 1'b0;
          goal_nxt  = 1'b0;
          chunk_nxt = CHUNK_LAST;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // most significant chunk first: acc = acc * 2^16 + chunk * b
        acc_nxt = {acc_r[AW-17:0], 16'b0} + {{(AW-40){1'b0}}, prod};
        if (chunk_r == '0) begin
          state_nxt = goal_r ? S_DIVC : S_DIST;
        end else begin
          chunk_nxt = chunk_r - CHW'(1);
        end
      end
      S_DIST: begin
        if (side_r) begin
          dist_r_nxt = dval;
        end else begin
          dist_l_nxt = dval;
        end
        chunk_nxt = CHUNK_LAST;
        acc_nxt   = '0;
        if (!side_r) begin
          side_nxt  = 1'b1;
          state_nxt = S_MUL;
        end else if (close_r) begin
          side_nxt  = 1'b0;
          goal_nxt  = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVC: begin
        // quotient saturates when num >= div * 2^15
        if (ovf) begin
          quot_nxt  = dsd_pkg::RPM_QMAX;
          state_nxt = S_SPD;
        end else begin
          rem_nxt   = num_hi[31:0];
          numlo_nxt = acc_r[QB-1:0];
          quot_nxt  = '0;
          step_nxt  = STW'(QB - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt   = qbit ? 32'(trial - {1'b0, div_r}) : trial[31:0];
        quot_nxt  = {quot_r[QB-2:0], qbit};
        numlo_nxt = {numlo_r[QB-2:0], 1'b0};
        if (step_r == '0) begin
          state_nxt = S_SPD;
        end else begin
          step_nxt = step_r - STW'(1);
        end
      end
      S_SPD: begin
        if (side_r) begin
          spd_r_nxt = sval;
          state_nxt = S_OUT;
        end else begin
          spd_l_nxt = sval;
          side_nxt  = 1'b1;
          chunk_nxt = CHUNK_LAST;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        // hold until the result register frees up
        if (!out_valid_r || pop) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt.left_rpm          = spd_l_r;
          out_word_nxt.right_rpm         = spd_r_r;
          out_word_nxt.left_distance_mm  = dist_l_r;
          out_word_nxt.right_distance_mm = dist_r_r;
          out_word_nxt.speed_new         = close_r;
          state_nxt                      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      spd_l_r     <= '0;
      spd_r_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      spd_l_r     <= spd_l_nxt;
      spd_r_r     <= spd_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r     <= side_nxt;
    goal_r     <= goal_nxt;
    chunk_r    <= chunk_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    numlo_r    <= numlo_nxt;
    quot_r     <= quot_nxt;
    step_r     <= step_nxt;
    dist_l_r   <= dist_l_nxt;
    dist_r_r   <= dist_r_nxt;
    out_word_r <= out_word_nxt;
    if (job_take) begin
      close_r  <= job_data[JOB_W-1];
      div_r    <= job_data[JOB_W-2 -: 32];
      mag_lw_r <= magnitude(j_lw);
      mag_rw_r <= magnitude(j_rw);
      mag_lt_r <= magnitude(j_lt);
      mag_rt_r <= magnitude(j_rt);
      neg_lw_r <= j_lw[CW-1];
      neg_rw_r <= j_rw[CW-1];
      neg_lt_r <= j_lt[CW-1];
      neg_rt_r <= j_rt[CW-1];
    end
  end

endmodule

// File: rtl/core/dual_encoder_speed_distance_top.sv
// The sample rate is limited by the shared 16x24 multiplier, which works on (COUNT_WIDTH-1)/16+1
// chunks (2 by default), and by the 15-step rpm divider in the back end, which is used only
// when a speed window closes. The back end takes a new job only when idle; a job queue of
// JOB_DEPTH words absorbs bursts meanwhile.
// Reset (rst_n low, synchronous): counters, speeds, queues clear; registers reload defaults.
module dual_encoder_speed_distance_top #(
  parameter int COUNT_WIDTH = 32,
  parameter int JOB_DEPTH   = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  dsd_pkg::in_word_t           in_word,
  output logic                        out_empty,
  input  logic                        out_pop,
  output dsd_pkg::out_word_t          out_word,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dsd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [dsd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [dsd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int JOB_W = 1 + 32 + 4 * COUNT_WIDTH;

  logic [15:0] window_ms_r, window_ms_nxt;
  logic [15:0] ppr_r, ppr_nxt;
  logic [23:0] mm_r, mm_nxt;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  logic             job_push, job_take, job_valid;
  logic [JOB_W-1:0] job_wdata, job_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[dsd_pkg::CFG_AW-1:2];

  always_comb begin
    window_ms_nxt = window_ms_r;
    ppr_nxt       = ppr_r;
    mm_nxt        = mm_r;
    if (cfg_wr) begin
      case (cfg_idx)
        dsd_pkg::REG_WINDOW_MS:      window_ms_nxt = cfg_pwdata[15:0];
        dsd_pkg::REG_PULSES_PER_REV: ppr_nxt       = cfg_pwdata[15:0];
        dsd_pkg::REG_MM_PER_PULSE:   mm_nxt        = cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dsd_pkg::REG_WINDOW_MS:      cfg_prdata = {16'b0, window_ms_r};
      dsd_pkg::REG_PULSES_PER_REV: cfg_prdata = {16'b0, ppr_r};
      dsd_pkg::REG_MM_PER_PULSE:   cfg_prdata = {8'b0, mm_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= dsd_pkg::WINDOW_MS_RST;
      ppr_r       <= dsd_pkg::PULSES_PER_REV_RST;
      mm_r        <= dsd_pkg::MM_PER_PULSE_RST;
    end else begin
      window_ms_r <= window_ms_nxt;
      ppr_r       <= ppr_nxt;
      mm_r        <= mm_nxt;
    end
  end

  dsd_front #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (in_push),
    .in_word        (in_word),
    .full           (in_full),
    .window_ms      (window_ms_r),
    .pulses_per_rev (ppr_r),
    .job_push       (job_push),
    .job_data       (job_wdata)
  );

  dsd_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .full    (in_full),
    .rd_en   (job_take),
    .rd_data (job_rdata),
    .valid   (job_valid)
  );

  dsd_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (job_valid),
    .job_data         (job_rdata),
    .job_take         (job_take),
    .mm_per_pulse_q16 (mm_r),
    .out_word         (out_word),
    .empty            (out_empty),
    .pop              (out_pop)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for dual_encoder_speed_distance_top: encoder samples are pushed
// in, each result word is compared against an in-bench speed/distance predictor.
// Depends on dsd_pkg (word types, register indexes, reset values).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COUNT_LIMIT  = 64'sd2147483647;
  localparam longint DIST_LIMIT   = 64'sd2147483647;
  localparam longint RPM_LIMIT    = 64'sd32767;
  localparam int     LATENCY_TAIL = 40;
  localparam int     PHASES       = 6;
  localparam int     PHASE_ITEMS  = 150;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE} pop_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_push;
  logic                         in_full;
  dsd_pkg::in_word_t            in_word;
  logic                         out_empty;
  logic                         out_pop;
  dsd_pkg::out_word_t           out_word;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [dsd_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [dsd_pkg::CFG_DW-1:0]   cfg_pwdata;
  logic [dsd_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  // predictor copy of registers and state
  logic [15:0]         win_cfg;
  logic [15:0]         ppr_cfg;
  logic [23:0]         mm_cfg;
  bit                  prev_la;
  bit                  prev_ra;
  longint              left_win_cnt;
  longint              right_win_cnt;
  longint              left_trav;
  longint              right_trav;
  int                  elapsed;
  logic signed [15:0]  left_speed;
  logic signed [15:0]  right_speed;

  dsd_pkg::out_word_t  readings_due[$];
  dsd_pkg::out_word_t  oldest_due;
  int                  errors;
  int                  results_seen;
  int                  burst_left;
  pop_mode_t           pop_mode;
  int                  mode_left;

  dual_encoder_speed_distance_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_word     (in_word),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_word    (out_word),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch %s at word %0d: got %0d, want %0d", what, results_seen, got, want);
    end
  endtask

  function automatic longint bump_count(longint v, bit up);
    if (up) return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 1;
    return (v <= -COUNT_LIMIT) ? -COUNT_LIMIT : v - 1;
  endfunction

  function automatic logic signed [15:0] wheel_rpm(longint cnt, longint ticks, longint ppr);
    longint q;
    q = ((cnt < 0) ? -cnt : cnt) * 60000 / (ppr * ticks);
    if (q > RPM_LIMIT) q = RPM_LIMIT;
    return 16'((cnt < 0) ? -q : q);
  endfunction

  // truncate toward zero: scale the magnitude, restore the sign afterwards
  function automatic logic signed [31:0] wheel_distance(longint cnt, longint mm);
    longint a;
    longint d;
    a = (cnt < 0) ? -cnt : cnt;
    d = (a / 65536) * mm + ((a % 65536) * mm) / 65536;
    if (d > DIST_LIMIT) d = DIST_LIMIT;
    return 32'((cnt < 0) ? -d : d);
  endfunction

  function automatic dsd_pkg::out_word_t next_readings(dsd_pkg::in_word_t w);
    dsd_pkg::out_word_t r;
    int                 n;
    longint             ppr;
    r = '0;
    if (w.clear_distance) begin
      left_trav  = 0;
      right_trav = 0;
    end
    if (w.left_a && !prev_la) begin
      left_win_cnt = bump_count(left_win_cnt, w.left_b);
      left_trav    = bump_count(left_trav, w.left_b);
    end
    if (w.right_a && !prev_ra) begin
      right_win_cnt = bump_count(right_win_cnt, w.right_b);
      right_trav    = bump_count(right_trav, w.right_b);
    end
    prev_la = w.left_a;
    prev_ra = w.right_a;
    if (w.ms_tick) begin
      n = elapsed + 1;
      // a zero window closes on every tick
      if (n >= int'(win_cfg)) begin
        ppr           = (ppr_cfg == 16'd0) ? 64'd1 : longint'(ppr_cfg);
        left_speed    = wheel_rpm(left_win_cnt, n, ppr);
        right_speed   = wheel_rpm(right_win_cnt, n, ppr);
        left_win_cnt  = 0;
        right_win_cnt = 0;
        elapsed       = 0;
        r.speed_new   = 1'b1;
      end else begin
        elapsed = n & 16'hFFFF;
      end
    end
    r.left_rpm          = left_speed;
    r.right_rpm         = right_speed;
    r.left_distance_mm  = wheel_distance(left_trav, longint'(mm_cfg));
    r.right_distance_mm = wheel_distance(right_trav, longint'(mm_cfg));
    return r;
  endfunction

  function automatic dsd_pkg::in_word_t sample_of(bit la, bit lb, bit ra, bit rb, bit tick,
                                                  bit clr);
    dsd_pkg::in_word_t w;
    w.left_a         = la;
    w.left_b         = lb;
    w.right_a        = ra;
    w.right_b        = rb;
    w.ms_tick        = tick;
    w.clear_distance = clr;
    return w;
  endfunction

  task automatic send_sample(dsd_pkg::in_word_t w);
    int gap;
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
    readings_due.push_back(next_readings(w));
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 30);
    end
  endtask

  // hold off the sender until every word pushed so far has come back
  task automatic drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    mask        = (idx == dsd_pkg::REG_MM_PER_PULSE) ? 32'h00FF_FFFF : 32'h0000_FFFF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      dsd_pkg::REG_WINDOW_MS:      win_cfg = val[15:0];
      dsd_pkg::REG_PULSES_PER_REV: ppr_cfg = val[15:0];
      default:                     mm_cfg  = val[23:0];
    endcase
    // read back through the same port
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd != (val & mask)) flag_mismatch("register readback", rd, val & mask);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (readings_due.size() == 0) begin
          flag_mismatch("unexpected word, left distance", out_word.left_distance_mm, 0);
        end else begin
          oldest_due = readings_due.pop_front();
          if (out_word.left_rpm !== oldest_due.left_rpm)
            flag_mismatch("left_rpm", out_word.left_rpm, oldest_due.left_rpm);
          if (out_word.right_rpm !== oldest_due.right_rpm)
            flag_mismatch("right_rpm", out_word.right_rpm, oldest_due.right_rpm);
          if (out_word.left_distance_mm !== oldest_due.left_distance_mm)
            flag_mismatch("left_distance_mm", out_word.left_distance_mm,
                          oldest_due.left_distance_mm);
          if (out_word.right_distance_mm !== oldest_due.right_distance_mm)
            flag_mismatch("right_distance_mm", out_word.right_distance_mm,
                          oldest_due.right_distance_mm);
          if (out_word.speed_new !== oldest_due.speed_new)
            flag_mismatch("speed_new", out_word.speed_new, oldest_due.speed_new);
        end
        results_seen++;
      end
      if (mode_left <= 0) begin
        pop_mode  = pop_mode_t'($urandom_range(2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        POP_ALWAYS: out_pop <= 1'b1;
        POP_COIN:   out_pop <= ($urandom_range(1) == 1);
        default:    out_pop <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // A high on the first sample after reset is a rising edge
  task automatic test_first_edge;
    send_sample(sample_of(1, 1, 1, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 0, 0));
    send_sample(sample_of(1, 0, 1, 1, 0, 0));
  endtask

  task automatic test_clear_distance;
    send_sample(sample_of(0, 0, 0, 0, 0, 0));
    // clear first, then count the edge of the same sample
    send_sample(sample_of(1, 1, 1, 1, 0, 1));
    send_sample(sample_of(1, 1, 1, 1, 0, 1));
  endtask

  task automatic test_rpm_saturation;
    drain;
    write_reg(dsd_pkg::REG_WINDOW_MS, 32'd2);
    write_reg(dsd_pkg::REG_PULSES_PER_REV, 32'd1);
    write_reg(dsd_pkg::REG_MM_PER_PULSE, 32'h00FF_FFFF);
    send_sample(sample_of(0, 0, 0, 0, 0, 0));
    send_sample(sample_of(1, 1, 1, 0, 1, 0));
    send_sample(sample_of(0, 0, 0, 0, 1, 0));
    send_sample(sample_of(1, 1, 1, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 0, 0));
    send_sample(sample_of(1, 1, 1, 0, 1, 0));
    send_sample(sample_of(0, 0, 0, 0, 1, 0));
  endtask

  // shrink the window after some ticks: the next tick closes it over all elapsed ticks
  task automatic test_short_window;
    drain;
    write_reg(dsd_pkg::REG_WINDOW_MS, 32'd20);
    write_reg(dsd_pkg::REG_PULSES_PER_REV, 32'd7);
    write_reg(dsd_pkg::REG_MM_PER_PULSE, 32'd1);
    send_sample(sample_of(1, 1, 1, 1, 1, 0));
    send_sample(sample_of(0, 1, 0, 1, 1, 0));
    send_sample(sample_of(1, 1, 1, 0, 1, 0));
    send_sample(sample_of(0, 1, 0, 0, 1, 0));
    drain;
    write_reg(dsd_pkg::REG_WINDOW_MS, 32'd3);
    send_sample(sample_of(1, 0, 1, 1, 1, 0));
  endtask

  task automatic test_zero_regs;
    drain;
    write_reg(dsd_pkg::REG_WINDOW_MS, 32'd0);
    write_reg(dsd_pkg::REG_PULSES_PER_REV, 32'd0);
    send_sample(sample_of(0, 1, 0, 0, 1, 0));
    send_sample(sample_of(1, 1, 1, 0, 1, 0));
    send_sample(sample_of(0, 0, 0, 1, 1, 1));
  endtask

  task automatic test_wide_regs;
    drain;
    write_reg(dsd_pkg::REG_WINDOW_MS, 32'hFFFF);
    write_reg(dsd_pkg::REG_PULSES_PER_REV, 32'hFFFF);
    write_reg(dsd_pkg::REG_MM_PER_PULSE, 32'h00FF_FFFF);
    send_sample(sample_of(1, 1, 1, 1, 1, 0));
    send_sample(sample_of(0, 1, 0, 1, 1, 0));
    send_sample(sample_of(1, 1, 1, 1, 1, 0));
    drain;
    write_reg(dsd_pkg::REG_WINDOW_MS, 32'd1);
    send_sample(sample_of(0, 1, 0, 1, 1, 0));
  endtask

  // mostly quadrature-like traffic with a steady direction, some raw noise
  task automatic test_random_traffic;
    dsd_pkg::in_word_t w;
    bit       la;
    bit       ra;
    bit       ldir;
    bit       rdir;
    int       tick_odds;
    int       v;
    la = 1'b0;
    ra = 1'b0;
    ldir = 1'b1;
    rdir = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain;
      case ($urandom_range(7))
        0:       v = 1;
        6:       v = 0;
        7:       v = 16'hFFFF;
        default: v = $urandom_range(2, 12);
      endcase
      write_reg(dsd_pkg::REG_WINDOW_MS, v);
      case ($urandom_range(5))
        0:       v = 1;
        1:       v = 0;
        2:       v = 16'hFFFF;
        default: v = $urandom_range(2, 1000);
      endcase
      write_reg(dsd_pkg::REG_PULSES_PER_REV, v);
      case ($urandom_range(3))
        0:       v = 1;
        1:       v = 24'hFF_FFFF;
        default: v = $urandom_range(1, 24'hFF_FFFF);
      endcase
      write_reg(dsd_pkg::REG_MM_PER_PULSE, v);
      tick_odds = $urandom_range(1, 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 12) begin
          w = dsd_pkg::in_word_t'(6'($urandom_range(63)));
        end else begin
          if ($urandom_range(49) == 0) ldir = !ldir;
          if ($urandom_range(49) == 0) rdir = !rdir;
          if ($urandom_range(2) == 0) la = !la;
          if ($urandom_range(2) == 0) ra = !ra;
          w = sample_of(la, ($urandom_range(19) == 0) ? !ldir : ldir,
                        ra, ($urandom_range(19) == 0) ? !rdir : rdir,
                        ($urandom_range(tick_odds) == 0), ($urandom_range(59) == 0));
        end
        send_sample(w);
      end
    end
  endtask

  initial begin
    in_push     <= 1'b0;
    in_word     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    win_cfg       = dsd_pkg::WINDOW_MS_RST;
    ppr_cfg       = dsd_pkg::PULSES_PER_REV_RST;
    mm_cfg        = dsd_pkg::MM_PER_PULSE_RST;
    prev_la       = 1'b0;
    prev_ra       = 1'b0;
    left_win_cnt  = 0;
    right_win_cnt = 0;
    left_trav     = 0;
    right_trav    = 0;
    elapsed       = 0;
    left_speed    = '0;
    right_speed   = '0;
    errors        = 0;
    results_seen  = 0;
    burst_left    = 20;
    pop_mode      = POP_ALWAYS;
    mode_left     = 50;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_edge;
    test_clear_distance;
    test_rpm_saturation;
    test_short_window;
    test_zero_regs;
    test_wide_regs;
    test_random_traffic;
    drain;
    repeat (LATENCY_TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
